FILE: sv/midi_clock_tempo_meter_assert.svh
// Assertion macros for the MIDI clock tempo meter.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MIDI_CLOCK_TEMPO_METER_ASSERT_SVH
`define MIDI_CLOCK_TEMPO_METER_ASSERT_SVH

// Condition that holds at every edge outside reset
`define MCTM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Condition that holds in the same cycle as its trigger
`define MCTM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds in the cycle after its trigger
`define MCTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mctm_pkg.sv
// Types and constants of the MIDI clock tempo meter.
// No dependencies; used by the channel interfaces and the top level.
package mctm_pkg;

  typedef logic [31:0] counter_t;
  typedef logic [29:0] freq_t;
  typedef logic [27:0] bpm_t;

  // Width of a tick count times one million
  localparam int PROD_W = 52;

  localparam logic [19:0] US_PER_SEC    = 20'd1000000;
  localparam bpm_t        BPM_NUMERATOR =
    28'((64'd60 * 64'd1000000 * 64'd100) / 64'd24);
  localparam bpm_t        TEMPO_RESET   = 28'd12000;
  localparam freq_t       FREQ_RESET    = 30'd1000000;

  // Register index, taken from paddr bit 2
  localparam logic REG_COUNT_UP   = 1'b0;
  localparam logic REG_CLOCK_FREQ = 1'b1;

endpackage

FILE: sv/mctm_in_if.sv
// Pulse channel of the MIDI clock tempo meter: one counter sample per item.
// Depends on mctm_pkg.
interface mctm_in_if import mctm_pkg::*; ();
  logic     valid;
  logic     ready;
  counter_t counter_value;

  modport source (output valid, output counter_value, input ready);
  modport sink (input valid, input counter_value, output ready);
endinterface

FILE: sv/mctm_out_if.sv
// Result channel of the MIDI clock tempo meter: one tempo report per item.
// Depends on mctm_pkg.
interface mctm_out_if import mctm_pkg::*; ();
  logic     valid;
  logic     ready;
  bpm_t     scaled_bpm;
  logic     tempo_valid;
  counter_t interval_len;
  counter_t pulse_stamp;

  modport source (output valid, output scaled_bpm, output tempo_valid,
                  output interval_len, output pulse_stamp, input ready);
  modport sink (input valid, input scaled_bpm, input tempo_valid,
                input interval_len, input pulse_stamp, output ready);
endinterface

FILE: sv/midi_clock_tempo_meter.sv
// MIDI clock tempo meter: interval averaging and tempo conversion.
// Depends on mctm_pkg, mctm_in_if, mctm_out_if and midi_clock_tempo_meter_assert.svh.
//
// Usage:
//   in_ch carries one item per MIDI clock pulse: the timestamp counter value
//   sampled at that pulse. out_ch returns exactly one item per pulse: tempo
//   in hundredths of BPM (zero until the first full block), the valid flag,
//   the latest nonzero interval and the pulse timestamp.
//   cfg_* is an APB write/read port: count_up at 0x0, clock_freq_hz at 0x4.
//   Write it only while the block is idle.
// Sequence:
//   A priming or zero-interval pulse goes from S_IDLE straight to S_FIN; an
//   ordinary pulse passes S_MUL1 and S_CMP first. The pulse that completes a
//   block of AVG_BLOCK intervals runs one bit-serial restoring divider three
//   times (sum / AVG_BLOCK, ticks to microseconds, numerator / microseconds)
//   in S_DIVA, S_DIVF and S_DIVB, with S_MUL2 between the first two; S_DIVB is skipped on zero microseconds.
//   in_ch is ready whenever no pulse is in work; one pulse at a time.
// Reset and stall:
//   rst_n (synchronous, active low) clears all measurement state, sets the
//   tempo to 120.00 BPM and the registers to their defaults. A stalled
//   out_ch holds its item; the next pulse is accepted and worked on, and
//   waits only for the output register to free up.
module midi_clock_tempo_meter import mctm_pkg::*; #(
  parameter int AVG_BLOCK = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  mctm_in_if.sink     in_ch,
  mctm_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

`include "midi_clock_tempo_meter_assert.svh"

  localparam int SUM_W  = 32 + $clog2(AVG_BLOCK);
  localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int CNT_W  = $clog2(AVG_BLOCK + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_DIVA = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_DIVF = 3'd5;
  localparam logic [2:0] S_DIVB = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]        state_r;
  logic              up_r;
  freq_t             freq_r;
  counter_t          prev_r;
  counter_t          stamp_r;
  counter_t          last_iv_r;
  counter_t          iv_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  bpm_t              tempo_r;
  logic              valid_r;
  logic [DIV_W-1:0]  num_r;
  logic [DIV_W-1:0]  den_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              out_valid_r;
  bpm_t              out_bpm_r;
  logic              out_tv_r;
  counter_t          out_iv_r;
  counter_t          out_stamp_r;

  logic              in_take;
  logic              cfg_wr;
  counter_t          iv_nxt;
  freq_t             freq_eff;
  counter_t          mul_a;
  logic [PROD_W-1:0] mul_p;
  logic [SUM_W-1:0]  sum_nxt;
  logic [DIV_W:0]    rem_sh;
  logic              div_ge;
  logic [DIV_W-1:0]  rem_nxt;
  logic [DIV_W-1:0]  num_step_nxt;
  logic              div_done;
  logic              out_free;

  // Handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && (state_r == S_IDLE);
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready  = 1'b1;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Register readback
  always_comb begin
    case (cfg_paddr[2])
      REG_COUNT_UP:   cfg_prdata = {31'b0, up_r};
      REG_CLOCK_FREQ: cfg_prdata = {2'b0, freq_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Interval with 32-bit wrap, direction per count_up
  assign iv_nxt   = up_r ? (in_ch.counter_value - prev_r) : (prev_r - in_ch.counter_value);
  assign freq_eff = (freq_r == '0) ? 30'd1 : freq_r;

  // Shared multiplier: ticks times one million
  assign mul_a = (state_r == S_MUL1) ? iv_r : num_r[31:0];
  assign mul_p = PROD_W'(mul_a) * PROD_W'(US_PER_SEC);

  assign sum_nxt = sum_r + SUM_W'(iv_r);

  // One step of the restoring divider; quotient bits shift into num_r
  assign rem_sh       = {rem_r, num_r[DIV_W-1]};
  assign div_ge       = rem_sh >= {1'b0, den_r};
  assign rem_nxt      = div_ge ? DIV_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_W-1:0];
  assign num_step_nxt = {num_r[DIV_W-2:0], div_ge};
  assign div_done     = (dcnt_r == '0);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r   <= 1'b0;
      freq_r <= FREQ_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_COUNT_UP:   up_r   <= cfg_pwdata[0];
        REG_CLOCK_FREQ: freq_r <= cfg_pwdata[29:0];
        default:        up_r   <= up_r;
      endcase
    end
  end

  // Sequencer: measurement state and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      prev_r    <= '0;
      stamp_r   <= '0;
      last_iv_r <= '0;
      sum_r     <= '0;
      cnt_r     <= '0;
      tempo_r   <= TEMPO_RESET;
      valid_r   <= 1'b0;
      dcnt_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            stamp_r <= in_ch.counter_value;
            prev_r  <= in_ch.counter_value;
            iv_r    <= iv_nxt;
            if (prev_r == '0 || iv_nxt == '0) begin
              state_r <= S_FIN;
            end else begin
              last_iv_r <= iv_nxt;
              state_r   <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          num_r   <= DIV_W'(mul_p);
          state_r <= S_CMP;
        end
        S_CMP: begin
          // Drop intervals under one microsecond
          if (num_r >= DIV_W'(freq_eff)) begin
            if (cnt_r == CNT_W'(AVG_BLOCK - 1)) begin
              num_r   <= DIV_W'(sum_nxt);
              den_r   <= DIV_W'(AVG_BLOCK);
              rem_r   <= '0;
              dcnt_r  <= DCNT_W'(DIV_W);
              sum_r   <= '0;
              cnt_r   <= '0;
              state_r <= S_DIVA;
            end else begin
              sum_r   <= sum_nxt;
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_FIN;
            end
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DIVA, S_DIVF, S_DIVB: begin
          if (!div_done) begin
            num_r  <= num_step_nxt;
            rem_r  <= rem_nxt;
            dcnt_r <= dcnt_r - 1'b1;
          end else if (state_r == S_DIVA) begin
            state_r <= S_MUL2;
          end else if (state_r == S_DIVF) begin
            // Zero microseconds keeps the old tempo
            if (num_r == '0) begin
              state_r <= S_FIN;
            end else begin
              den_r   <= num_r;
              num_r   <= DIV_W'(BPM_NUMERATOR);
              rem_r   <= '0;
              dcnt_r  <= DCNT_W'(DIV_W);
              state_r <= S_DIVB;
            end
          end else begin
            tempo_r <= num_r[27:0];
            valid_r <= 1'b1;
            state_r <= S_FIN;
          end
        end
        S_MUL2: begin
          // Average ticks to microseconds: load product over frequency
          num_r   <= DIV_W'(mul_p);
          den_r   <= DIV_W'(freq_eff);
          rem_r   <= '0;
          dcnt_r  <= DCNT_W'(DIV_W);
          state_r <= S_DIVF;
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_bpm_r   <= valid_r ? tempo_r : '0;
      out_tv_r    <= valid_r;
      out_iv_r    <= last_iv_r;
      out_stamp_r <= stamp_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scaled_bpm   = out_bpm_r;
  assign out_ch.tempo_valid  = out_tv_r;
  assign out_ch.interval_len = out_iv_r;
  assign out_ch.pulse_stamp  = out_stamp_r;

  `MCTM_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, state_r != S_IDLE, "pulse accepted but sequencer stayed idle")
  `MCTM_ASSERT_IMPLY(a_bpm_zero_until_valid, out_ch.valid && !out_ch.tempo_valid, out_ch.scaled_bpm == '0, "tempo reported without a valid measurement")
  `MCTM_ASSERT_ALWAYS(a_count_in_block, 32'(cnt_r) < AVG_BLOCK, "sample count ran past the block size")
  `MCTM_ASSERT_IMPLY(a_tempo_divisor_nonzero, state_r == S_DIVB, den_r != '0, "tempo division started with zero microseconds")

endmodule
